[sv/hv3_pkg.sv]
// Package for the 3-D hypervolume sweep: sequencer states, fixed widths and the reset reference point.
// No dependencies.
`default_nettype none
package hv3_pkg;
  localparam int COORD_BITS = 16;
  localparam int AREA_W = 2 * COORD_BITS + 2;
  localparam int VOL_W  = 3 * COORD_BITS;
  localparam logic [COORD_BITS-1:0] REF_RESET = 16'd18022;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DEL,
    ST_FLUSH,
    ST_NEWRECT,
    ST_ADD,
    ST_MOVE,
    ST_PUT,
    ST_VOL,
    ST_CLOSE
  } state_t;
endpackage
`default_nettype wire

[sv/hypervolume_3d_sweep.sv]
// Top level of the 3-D hypervolume sweep: staircase memory and its sequencer.
// Depends on hv3_pkg.
`default_nettype none
// Takes one point per start while busy is low. A point walks the staircase
// memory one entry per cycle (reads are registered): a scan to find its
// slot, a pass over the entries it covers, then a shift of the table tail to
// open or close a gap. A dominated point ends after its scan and a check. The
// last point of a set adds the volume and close steps, and the result (volume,
// overflow) shows for one cycle on result_valid right after busy drops; the
// receiver cannot stall. After reset no clearing pass is needed: only entries
// below the count are used.
module hypervolume_3d_sweep #(
  parameter int MAX_POINTS = 256
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire  [hv3_pkg::COORD_BITS-1:0] coord_x,
  input  wire  [hv3_pkg::COORD_BITS-1:0] coord_y,
  input  wire  [hv3_pkg::COORD_BITS-1:0] coord_z,
  input  wire                            last_point,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [hv3_pkg::COORD_BITS-1:0] cfg_data,
  output logic                           result_valid,
  output logic [hv3_pkg::VOL_W-1:0]      volume,
  output logic                           overflow
);
  localparam int CB  = hv3_pkg::COORD_BITS;
  localparam int PW  = 2 * CB;
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int ARW = hv3_pkg::AREA_W;
  localparam int VW  = hv3_pkg::VOL_W;

  hv3_pkg::state_t state, state_next;

  logic [PW-1:0] mem [MAX_POINTS];
  logic [PW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic          wen;
  logic [PW-1:0] wdata;

  logic [CB-1:0] ref_pt, px, py, pz, prev_z, pred_y, hy, gap;
  logic [CB-1:0] del_x, del_y, nxt_x, rw, rh, nw, nh;
  logic [CB-1:0] cur_x, cur_y;
  logic [CW-1:0] count, pos, idx, endp, mv_left, removed, idx_inc, dst_dn;
  logic [AW-1:0] wa_q;
  logic          last_q, ovf, have_del, pend, mv_up, rd_ok;
  logic          dominated, no_room;
  logic [ARW-1:0]    area, area_w;
  logic [VW-1:0]     vol;
  logic [PW-1:0]     rect_prod, new_prod;
  logic [ARW+CB-1:0] vol_prod;

  function automatic logic [CB-1:0] ssub(input logic [CB-1:0] a, input logic [CB-1:0] b);
    ssub = (a > b) ? a - b : '0;
  endfunction

  function automatic logic [CB-1:0] clampc(input logic [CB-1:0] v, input logic [CB-1:0] r);
    clampc = (v > r) ? r : v;
  endfunction

  function automatic logic [ARW-1:0] area_less(input logic [ARW-1:0] a,
                                               input logic [PW-1:0] p);
    area_less = (a > ARW'(p)) ? a - ARW'(p) : '0;
  endfunction

  assign cur_x = rdata[PW-1:CB];
  assign cur_y = rdata[CB-1:0];
  assign busy = (state != hv3_pkg::ST_IDLE);
  assign cfg_ready = (state == hv3_pkg::ST_IDLE);
  assign removed = endp - pos;
  assign idx_inc = idx + CW'(1);
  assign dst_dn = idx - removed + CW'(1);
  assign dominated = (pos != '0) && (pred_y <= py);
  assign no_room = (endp == pos) && (count == CW'(MAX_POINTS));
  assign rect_prod = rw * rh;
  assign new_prod = nw * nh;
  assign vol_prod = area * gap;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      hv3_pkg::ST_IDLE: begin
        if (start) state_next = (count == '0) ? hv3_pkg::ST_CHECK : hv3_pkg::ST_SCAN;
      end
      hv3_pkg::ST_SCAN: begin
        if (cur_x > px || idx_inc == count) state_next = hv3_pkg::ST_CHECK;
      end
      hv3_pkg::ST_CHECK: begin
        if (dominated) state_next = last_q ? hv3_pkg::ST_VOL : hv3_pkg::ST_IDLE;
        else state_next = (pos == count) ? hv3_pkg::ST_FLUSH : hv3_pkg::ST_DEL;
      end
      hv3_pkg::ST_DEL: begin
        if (cur_y < py || idx_inc == count) state_next = hv3_pkg::ST_FLUSH;
      end
      hv3_pkg::ST_FLUSH: begin
        if (no_room) state_next = last_q ? hv3_pkg::ST_VOL : hv3_pkg::ST_IDLE;
        else state_next = hv3_pkg::ST_NEWRECT;
      end
      hv3_pkg::ST_NEWRECT: state_next = hv3_pkg::ST_ADD;
      hv3_pkg::ST_ADD:     state_next = hv3_pkg::ST_MOVE;
      hv3_pkg::ST_MOVE: begin
        if (mv_left == '0) state_next = hv3_pkg::ST_PUT;
      end
      hv3_pkg::ST_PUT:     state_next = last_q ? hv3_pkg::ST_VOL : hv3_pkg::ST_IDLE;
      hv3_pkg::ST_VOL:     state_next = hv3_pkg::ST_CLOSE;
      hv3_pkg::ST_CLOSE:   state_next = hv3_pkg::ST_IDLE;
      default:             state_next = hv3_pkg::ST_IDLE;
    endcase
  end

  // Memory port control; reads run one entry ahead of the entry in rdata.
  always_comb begin
    raddr = '0;
    wen = 1'b0;
    waddr = wa_q;
    wdata = rdata;
    case (state)
      hv3_pkg::ST_SCAN, hv3_pkg::ST_DEL: raddr = idx_inc[AW-1:0];
      hv3_pkg::ST_CHECK: raddr = pos[AW-1:0];
      hv3_pkg::ST_MOVE: begin
        raddr = idx[AW-1:0];
        wen = rd_ok;
      end
      hv3_pkg::ST_PUT: begin
        wen = 1'b1;
        waddr = pos[AW-1:0];
        wdata = {px, py};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hv3_pkg::ST_IDLE;
      ref_pt <= hv3_pkg::REF_RESET;
      count <= '0; area <= '0; vol <= '0; prev_z <= '0; ovf <= 1'b0;
      result_valid <= 1'b0; volume <= '0; overflow <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      case (state)
        hv3_pkg::ST_IDLE: begin
          if (cfg_valid) ref_pt <= cfg_data;
          if (start) begin
            px <= clampc(coord_x, ref_pt);
            py <= clampc(coord_y, ref_pt);
            pz <= clampc(coord_z, ref_pt);
            last_q <= last_point;
            pos <= '0; idx <= '0;
          end
        end
        hv3_pkg::ST_SCAN: begin
          // rdata holds entry idx
          if (cur_x <= px) begin
            pred_y <= cur_y;
            if (idx_inc == count) pos <= count;
            else idx <= idx_inc;
          end else begin
            pos <= idx;
          end
        end
        hv3_pkg::ST_CHECK: begin
          gap <= ssub(pz, prev_z);
          hy <= (pos != '0) ? pred_y : ref_pt;
          idx <= pos; endp <= pos;
          have_del <= 1'b0;
          pend <= 1'b0;
          area_w <= area;
        end
        hv3_pkg::ST_DEL: begin
          // a covered entry's width needs the x of the entry after it
          if (pend) area_w <= area_less(area_w, rect_prod);
          pend <= have_del;
          if (have_del) begin
            rw <= ssub(cur_x, del_x);
            rh <= ssub(hy, del_y);
          end
          if (cur_y >= py) begin
            del_x <= cur_x; del_y <= cur_y;
            have_del <= 1'b1;
            idx <= idx_inc; endp <= idx_inc;
          end else begin
            nxt_x <= cur_x;
          end
        end
        hv3_pkg::ST_FLUSH: begin
          if (pend) area_w <= area_less(area_w, rect_prod);
          pend <= have_del && (endp == count);
          rw <= ssub(ref_pt, del_x);
          rh <= ssub(hy, del_y);
          nw <= (endp == count) ? ssub(ref_pt, px) : ssub(nxt_x, px);
          nh <= ssub(hy, py);
          if (no_room) ovf <= 1'b1;
        end
        hv3_pkg::ST_NEWRECT: begin
          if (pend) area_w <= area_less(area_w, rect_prod);
          pend <= 1'b0;
        end
        hv3_pkg::ST_ADD: begin
          // volume grows with the area before this point
          area <= area_w + ARW'(new_prod);
          vol <= vol + vol_prod[VW-1:0];
          prev_z <= pz;
          rd_ok <= 1'b0;
          if (endp == pos) begin
            idx <= count - CW'(1);
            mv_left <= count - pos;
            mv_up <= 1'b1;
          end else begin
            idx <= endp;
            mv_left <= (removed > CW'(1)) ? count - endp : '0;
            mv_up <= 1'b0;
          end
        end
        hv3_pkg::ST_MOVE: begin
          if (mv_left != '0) begin
            rd_ok <= 1'b1;
            wa_q <= mv_up ? idx_inc[AW-1:0] : dst_dn[AW-1:0];
            idx <= mv_up ? idx - CW'(1) : idx_inc;
            mv_left <= mv_left - CW'(1);
          end else begin
            rd_ok <= 1'b0;
          end
        end
        hv3_pkg::ST_PUT: begin
          count <= (endp == pos) ? count + CW'(1) : count - removed + CW'(1);
        end
        hv3_pkg::ST_VOL: begin
          gap <= ssub(ref_pt, prev_z);
        end
        hv3_pkg::ST_CLOSE: begin
          volume <= vol + vol_prod[VW-1:0];
          overflow <= ovf;
          result_valid <= 1'b1;
          count <= '0; area <= '0; vol <= '0; prev_z <= '0; ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for hypervolume_3d_sweep: point sets are driven through
// the start/busy port; every result is checked against a staircase predictor
// kept in the bench or a table volume. Depends on hv3_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  localparam int VOL_W = hv3_pkg::VOL_W;
  localparam int AREA_W = hv3_pkg::AREA_W;
  localparam logic [15:0] REF_RESET = hv3_pkg::REF_RESET;

  localparam int MAXP = 256;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 2 * MAXP + 40;

  typedef struct packed {
    logic [VOL_W-1:0] vol;
    logic             ovf;
  } vol_res_t;

  typedef struct {
    logic [15:0]      x, y, z;
    bit               lst;
    bit               typed;
    logic [VOL_W-1:0] vol;
  } pt_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic last_point = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic result_valid;
  logic [VOL_W-1:0] volume;
  logic overflow;

  hypervolume_3d_sweep i_dut (
    .clk, .rst, .start, .busy, .coord_x, .coord_y, .coord_z, .last_point,
    .cfg_valid, .cfg_ready, .cfg_data, .result_valid, .volume, .overflow
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // staircase predictor state
  logic [15:0] ref_pt;
  logic [15:0] st_x [MAXP];
  logic [15:0] st_y [MAXP];
  int          st_cnt;
  logic [63:0] area;
  logic [63:0] vol_sum;
  logic [15:0] last_z;
  bit          lost_pt;

  vol_res_t vol_q[$];
  bit          next_typed;
  logic [VOL_W-1:0] next_vol;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  function automatic logic [63:0] sub0(logic [63:0] a, logic [63:0] b);
    return a > b ? a - b : 64'd0;
  endfunction

  function automatic logic [15:0] clamp(logic [15:0] v);
    return v > ref_pt ? ref_pt : v;
  endfunction

  task automatic clear_stairs();
    st_cnt = 0; area = 0; vol_sum = 0; last_z = 0; lost_pt = 0;
  endtask

  task automatic sweep_point(logic [15:0] ix, logic [15:0] iy, logic [15:0] iz, bit lst);
    logic [15:0] px, py, pz;
    logic [63:0] w, h;
    int pos, stop, removed, k;
    bit pred;
    px = clamp(ix); py = clamp(iy); pz = clamp(iz);
    pos = 0;
    while (pos < st_cnt && st_x[pos] <= px) pos++;
    pred = pos > 0;
    if (!(pred && st_y[pos-1] <= py)) begin
      stop = pos;
      while (stop < st_cnt && st_y[stop] >= py) stop++;
      removed = stop - pos;
      if (removed == 0 && st_cnt >= MAXP) begin
        lost_pt = 1;
      end else begin
        vol_sum = (vol_sum + area * sub0(pz, last_z)) & ((64'd1 << VOL_W) - 1);
        last_z = pz;
        for (k = pos; k < stop; k++) begin
          w = (k + 1 < st_cnt) ? sub0(st_x[k+1], st_x[k]) : sub0(ref_pt, st_x[k]);
          h = pred ? sub0(st_y[pos-1], st_y[k]) : sub0(ref_pt, st_y[k]);
          area = sub0(area, w * h);
        end
        w = (stop < st_cnt) ? sub0(st_x[stop], px) : sub0(ref_pt, px);
        h = pred ? sub0(st_y[pos-1], py) : sub0(ref_pt, py);
        area = (area + w * h) & ((64'd1 << AREA_W) - 1);
        if (removed == 0) begin
          for (k = st_cnt; k > pos; k--) begin
            st_x[k] = st_x[k-1]; st_y[k] = st_y[k-1];
          end
          st_cnt++;
        end else if (removed > 1) begin
          for (k = stop; k < st_cnt; k++) begin
            st_x[k-removed+1] = st_x[k]; st_y[k-removed+1] = st_y[k];
          end
          st_cnt -= removed - 1;
        end
        st_x[pos] = px; st_y[pos] = py;
      end
    end
    if (lst) begin
      vol_q.push_back({next_typed ? next_vol :
                       VOL_W'(vol_sum + area * sub0(ref_pt, last_z)), lost_pt});
      clear_stairs();
    end
  endtask

  // monitor: values read here are the ones before the edge
  always @(posedge clk) begin
    vol_res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst) begin
      if (result_valid) begin
        got = {volume, overflow};
        if (vol_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result vol=%0h ovf=%0b", volume, overflow);
        end else begin
          want = vol_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: vol exp %0h got %0h, ovf exp %0b got %0b",
                       want.vol, got.vol, want.ovf, got.ovf);
          end
        end
      end
      if (start && !busy) sweep_point(coord_x, coord_y, coord_z, last_point);
    end
  end

  task automatic idle_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pt(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit lst,
                         bit typed = 0, logic [VOL_W-1:0] tv = '0);
    next_typed <= typed;
    next_vol <= tv;
    start <= 1'b1;
    coord_x <= x; coord_y <= y; coord_z <= z; last_point <= lst;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    idle_gap();
  endtask

  // dropped points leave no result behind, so allow a worst-case walk too
  task automatic settle();
    start <= 1'b0;
    while (vol_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ref(logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    ref_pt = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_set(int npts);
    logic [15:0] z, x, y;
    int mode;
    z = 16'($urandom_range(ref_pt / 2 + 1));
    mode = $urandom_range(9);
    for (int i = 0; i < npts; i++) begin
      case (mode)
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1, 2: begin x = 16'($urandom_range(7) * 1024); y = 16'($urandom_range(7) * 1024); end
        default: begin
          x = 16'($urandom_range(ref_pt)); y = 16'($urandom_range(ref_pt));
        end
      endcase
      if ($urandom_range(19) == 0) z = 16'($urandom);
      else if ($urandom_range(29) == 0) z = z - 16'($urandom_range(200));
      else z = z + 16'($urandom_range(600));
      send_pt(x, y, z, i == npts - 1);
    end
  endtask

  pt_row_t dir_tab[] = '{
    '{16'd0, 16'd0, 16'd0, 1, 1, VOL_W'(64'd18022 * 18022 * 18022)},
    '{16'hffff, 16'hffff, 16'hffff, 1, 1, '0},
    '{16'd18022, 16'd0, 16'd0, 1, 1, '0},
    '{16'd4000, 16'd9000, 16'd100, 0, 0, '0},
    '{16'd4000, 16'd7000, 16'd200, 0, 0, '0},
    '{16'd4000, 16'd7000, 16'd300, 0, 0, '0},
    '{16'd8000, 16'd7000, 16'd400, 0, 0, '0},
    '{16'd2000, 16'd12000, 16'd350, 0, 0, '0},
    '{16'd9000, 16'd3000, 16'd500, 0, 0, '0},
    '{16'd1000, 16'd1000, 16'd600, 0, 0, '0},
    '{16'hffff, 16'd0, 16'hffff, 1, 0, '0},
    '{16'h5555, 16'haaaa, 16'h1234, 0, 0, '0},
    '{16'haaaa, 16'h5555, 16'h4321, 0, 0, '0},
    '{16'd0, 16'hffff, 16'h8000, 0, 0, '0},
    '{16'hffff, 16'd0, 16'hfffe, 1, 0, '0}
  };

  initial begin
    int pcts[4] = '{0, 78, 0, 14};
    logic [15:0] refs[5] = '{16'hffff, 16'd0, 16'd16384, 16'd1, REF_RESET};
    ref_pt = REF_RESET;
    clear_stairs();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_pt(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].lst,
              dir_tab[i].typed, dir_tab[i].vol);

    for (int ph = 0; ph < 8; ph++) begin
      int sent;
      idle_pct = pcts[ph % 4];
      if (ph > 0) write_ref(ph < 6 ? refs[ph-1] : 16'($urandom));
      sent = 0;
      while (sent < 140) begin
        int n;
        n = $urandom_range(4) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 10);
        random_set(n);
        sent += n;
        if ($urandom_range(30) == 0) settle();
      end
    end

    // staircase longer than the table: expect the overflow flag
    write_ref(16'hffff);
    idle_pct = 0;
    for (int i = 0; i < MAXP + 6; i++)
      send_pt(16'(i * 64), 16'(40000 - i * 64), 16'(i), i == MAXP + 5);
    write_ref(REF_RESET);
    random_set(5);

    settle();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
sv/hv3_pkg.sv
sv/hypervolume_3d_sweep.sv
tb/tb_top.sv
